// ===== design/pbb_pkg.sv =====
package pbb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned FactorW = 9;
  localparam int unsigned ProdW   = 16;

  localparam logic [FactorW-1:0] FullFactor = 9'd256;

  typedef enum logic [2:0] {
    MODE_COPY        = 3'd0,
    MODE_KEY         = 3'd1,
    MODE_TEST        = 3'd2,
    MODE_SRC_BLEND   = 3'd3,
    MODE_CONST_BLEND = 3'd4
  } blend_mode_t;

  typedef enum logic [2:0] {
    REG_BLEND_MODE      = 3'd0,
    REG_COLOR_KEY       = 3'd1,
    REG_ALPHA_REFERENCE = 3'd2,
    REG_CONSTANT_ALPHA  = 3'd3,
    REG_RASTER_WIDTH    = 3'd4,
    REG_RASTER_HEIGHT   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [2:0]  blend_mode;
    logic [31:0] color_key;
    logic [7:0]  alpha_reference;
    logic [8:0]  constant_alpha;
    logic [12:0] raster_width;
    logic [12:0] raster_height;
  } cfg_t;

  // index 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][ChanW-1:0] rgba_t;

  // after qualify stage
  typedef struct packed {
    rgba_t              src;
    rgba_t              dst;
    logic               we;
    logic [CoordW-1:0]  x;
    logic [CoordW-1:0]  y;
    logic               src_blend;
    logic               const_blend;
    logic [FactorW-1:0] src_factor;
    logic [FactorW-1:0] const_factor;
  } qual_t;

endpackage

// ===== design/pbb_cfg.sv =====
module pbb_cfg
  import pbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_mode      <= MODE_COPY;
      cfg.color_key       <= '0;
      cfg.alpha_reference <= '0;
      cfg.constant_alpha  <= FullFactor;
      cfg.raster_width    <= 13'd4096;
      cfg.raster_height   <= 13'd4096;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_BLEND_MODE:      cfg.blend_mode      <= cfg_data[2:0];
        REG_COLOR_KEY:       cfg.color_key       <= cfg_data;
        REG_ALPHA_REFERENCE: cfg.alpha_reference <= cfg_data[7:0];
        REG_CONSTANT_ALPHA:  cfg.constant_alpha  <= cfg_data[8:0];
        REG_RASTER_WIDTH:    cfg.raster_width    <= cfg_data[12:0];
        REG_RASTER_HEIGHT:   cfg.raster_height   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/pbb_qual.sv =====
module pbb_qual
  import pbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  rgba_t       in_src,
  input  rgba_t       in_dst,
  input  logic [12:0] in_x,
  input  logic [12:0] in_y,
  output logic        out_valid,
  input  logic        out_ready,
  output qual_t       out_item
);

  qual_t       item_next;
  logic        on_raster;
  logic        key_hit;
  logic [31:0] packed_src;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    packed_src = {in_src[0], in_src[1], in_src[2], in_src[3]};
    key_hit    = (packed_src == cfg.color_key);
    on_raster  = !in_x[12] && !in_y[12] &&
                 ({1'b0, in_x[11:0]} < cfg.raster_width) &&
                 ({1'b0, in_y[11:0]} < cfg.raster_height);

    item_next.src = in_src;
    item_next.dst = in_dst;
    item_next.x   = in_x[11:0];
    item_next.y   = in_y[11:0];
    item_next.we  = on_raster;
    case (blend_mode_t'(cfg.blend_mode))
      MODE_KEY:  if (key_hit) item_next.we = 1'b0;
      MODE_TEST: if (!(in_src[3] > cfg.alpha_reference)) item_next.we = 1'b0;
      default: ;
    endcase
    item_next.src_blend   = (cfg.blend_mode == MODE_SRC_BLEND);
    item_next.const_blend = (cfg.blend_mode == MODE_CONST_BLEND);
    // opaque source alpha counts as a full factor
    item_next.src_factor  = (in_src[3] == 8'hFF) ? FullFactor : {1'b0, in_src[3]};
    item_next.const_factor = (cfg.constant_alpha > FullFactor) ? FullFactor
                                                                 : cfg.constant_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== design/pbb_mix.sv =====
module pbb_mix
  import pbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  qual_t             in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output rgba_t             out_pix,
  output logic              out_we,
  output logic [CoordW-1:0] out_x,
  output logic [CoordW-1:0] out_y
);

  // factor stage
  logic               f_valid;
  logic               f_adv;
  rgba_t              f_src;
  rgba_t              f_dst;
  logic               f_we;
  logic [CoordW-1:0]  f_x;
  logic [CoordW-1:0]  f_y;
  logic [FactorW-1:0] f_factor;
  logic [FactorW-1:0] f_factor_next;
  logic [17:0]        alpha_prod;

  // product stage
  logic                  p_valid;
  logic                  p_adv;
  logic [3:0][ProdW-1:0] p_src_prod;
  logic [3:0][ProdW-1:0] p_dst_prod;
  logic                  p_we;
  logic [CoordW-1:0]     p_x;
  logic [CoordW-1:0]     p_y;
  logic [FactorW-1:0]    inv_factor;

  // output stage
  logic  o_adv;
  rgba_t pix_next;
  logic [ProdW-1:0] chan_sum;

  assign o_adv    = !out_valid || out_ready;
  assign p_adv    = !p_valid || o_adv;
  assign f_adv    = !f_valid || p_adv;
  assign in_ready = f_adv;

  always_comb begin
    alpha_prod = 18'(in_item.src_factor) * 18'(in_item.const_factor);
    if (in_item.src_blend) begin
      f_factor_next = alpha_prod[16:8];
    end else if (in_item.const_blend) begin
      f_factor_next = in_item.const_factor;
    end else begin
      // copy, key and test modes pass the source through unchanged
      f_factor_next = FullFactor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_adv) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv && in_valid) begin
      f_src    <= in_item.src;
      f_dst    <= in_item.dst;
      f_we     <= in_item.we;
      f_x      <= in_item.x;
      f_y      <= in_item.y;
      f_factor <= f_factor_next;
    end
  end

  assign inv_factor = FullFactor - f_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_adv) begin
      p_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_adv && f_valid) begin
      for (int i = 0; i < 4; i++) begin
        p_src_prod[i] <= ProdW'(f_src[i]) * ProdW'(f_factor);
        p_dst_prod[i] <= ProdW'(f_dst[i]) * ProdW'(inv_factor);
      end
      p_we <= f_we;
      p_x  <= f_x;
      p_y  <= f_y;
    end
  end

  // sum never exceeds 255 * 256, so it fits the product width
  always_comb begin
    chan_sum = '0;
    for (int i = 0; i < 4; i++) begin
      chan_sum    = p_src_prod[i] + p_dst_prod[i];
      pix_next[i] = p_we ? chan_sum[15:8] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_adv) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv && p_valid) begin
      out_pix <= pix_next;
      out_we  <= p_we;
      out_x   <= p_we ? p_x : '0;
      out_y   <= p_we ? p_y : '0;
    end
  end

endmodule

// ===== design/pixel_blit_blend_unit.sv =====
// channel  dir  handshake          contents
// s_       in   s_tvalid/s_tready  source pixel, destination pixel, coordinate
// m_       out  m_tvalid/m_tready  resulting pixel, coordinate; tuser write enable
// cfg_     in   cfg_valid/cfg_ready register index and write data
//
// one pixel request accepted per clock unless a stall on m_tready holds the pipeline
// stages: qualify (clip, key, test), factor multiply, channel multiplies, sum and mux
// rst clears the stage valid bits and loads the register reset values
// a stall on m_tready holds each full stage; empty stages still fill behind it
// cfg_ready is always high; a write lands in the next cycle
module pixel_blit_blend_unit
  import pbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue,
  // dst_alpha, pos_x, pos_y, zero pad
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_red, out_green, out_blue, out_alpha, out_x, out_y
  output logic [55:0] m_tdata,
  // write_enable
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t              cfg;
  rgba_t             in_src;
  rgba_t             in_dst;
  logic              q_valid;
  logic              q_ready;
  qual_t             q_item;
  rgba_t             out_pix;
  logic [CoordW-1:0] out_x;
  logic [CoordW-1:0] out_y;

  assign in_src = {s_tdata[31:24], s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};
  assign in_dst = {s_tdata[63:56], s_tdata[55:48], s_tdata[47:40], s_tdata[39:32]};

  pbb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pbb_qual u_qual (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_src    (in_src),
    .in_dst    (in_dst),
    .in_x      (s_tdata[76:64]),
    .in_y      (s_tdata[89:77]),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  pbb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (out_pix),
    .out_we    (m_tuser),
    .out_x     (out_x),
    .out_y     (out_y)
  );

  assign m_tdata = {out_y, out_x, out_pix[3], out_pix[2], out_pix[1], out_pix[0]};

endmodule
